@@ src/fmbs_pkg.sv @@
// Shared types, constants and helpers of the MP4 box splitter.
`default_nettype none
package fmbs_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W        = 2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SINK_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAG_SINK_EN = 2'd1;

    // Header geometry
    localparam int unsigned HDR_BYTES        = 16;
    localparam int unsigned HDR_SHORT_LEN    = 8;
    localparam int unsigned HDR_LONG_LEN     = 16;
    localparam int unsigned SIZE_LONG_OFFSET = 12;
    localparam int unsigned TYPE_OFFSET      = 4;
    localparam logic [31:0] SIZE_EXTENDED    = 32'd1;

    // Box type tags, big-endian ASCII
    localparam logic [31:0] TAG_FTYP = 32'h6674_7970;
    localparam logic [31:0] TAG_MOOV = 32'h6d6f_6f76;
    localparam logic [31:0] TAG_MOOF = 32'h6d6f_6f66;
    localparam logic [31:0] TAG_MDAT = 32'h6d64_6174;

    // Default depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_FTYP    = 3'd1,
        KIND_MOOV    = 3'd2,
        KIND_MOOF    = 3'd3,
        KIND_MDAT    = 3'd4
    } t_kind;

    // One queued command: a whole header burst or a single body byte
    typedef struct packed {
        logic                            is_hdr;
        logic                            hdr_long;
        logic [HDR_BYTES-1:0][7:0]       hdr;
        logic [7:0]                      body_byte;
        logic                            seg;
        logic                            restart;
        logic                            done;
        logic                            deliver;
    } t_cmd;

    // Queue status seen by the top level and the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // Map a box type tag to its kind
    function automatic t_kind classify(input logic [31:0] tag);
        t_kind k;
        k = KIND_UNKNOWN;
        if (tag == TAG_FTYP) begin
            k = KIND_FTYP;
        end else if (tag == TAG_MOOV) begin
            k = KIND_MOOV;
        end else if (tag == TAG_MOOF) begin
            k = KIND_MOOF;
        end else if (tag == TAG_MDAT) begin
            k = KIND_MDAT;
        end
        return k;
    endfunction

endpackage
`default_nettype wire

@@ src/fmbs_front.sv @@
// Front end: collects box headers, classifies boxes and issues commands.
`default_nettype none
module fmbs_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_acc,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_init_en,
    input  wire logic           i_frag_en,
    output fmbs_pkg::t_cmd      o_cmd,
    output logic                o_push
);

    logic [fmbs_pkg::HDR_BYTES-1:0][7:0] r_hdr, n_hdr;
    logic [4:0]            r_count, n_count;
    logic [31:0]           r_left, n_left;
    fmbs_pkg::t_kind       r_kind, n_kind;
    logic                  r_init_done, n_init_done;

    logic [4:0]            cnt_inc;
    logic                  at_short, at_long, in_body, hdr_done, bad_size, is_final;
    logic                  done_b, dlv, push;
    logic [31:0]           size8, size16, size_sel, hlen, body_len;
    fmbs_pkg::t_kind       new_kind, use_kind;

    // Classify the header and decide the command for this byte
    always_comb begin
        n_hdr = r_hdr;
        if (r_left == 32'd0) begin
            n_hdr[r_count[3:0]] = i_in_byte;
        end
        cnt_inc  = r_count + 5'd1;
        at_short = (cnt_inc == 5'(fmbs_pkg::HDR_SHORT_LEN));
        at_long  = (cnt_inc == 5'(fmbs_pkg::HDR_LONG_LEN));
        size8    = {n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3]};
        size16   = {n_hdr[fmbs_pkg::SIZE_LONG_OFFSET],
                    n_hdr[fmbs_pkg::SIZE_LONG_OFFSET + 1],
                    n_hdr[fmbs_pkg::SIZE_LONG_OFFSET + 2],
                    n_hdr[fmbs_pkg::SIZE_LONG_OFFSET + 3]};
        size_sel = at_long ? size16 : size8;
        hlen     = at_long ? 32'(fmbs_pkg::HDR_LONG_LEN) : 32'(fmbs_pkg::HDR_SHORT_LEN);
        bad_size = (size_sel < hlen);
        body_len = size_sel - hlen;
        new_kind = fmbs_pkg::classify({n_hdr[fmbs_pkg::TYPE_OFFSET],
                                       n_hdr[fmbs_pkg::TYPE_OFFSET + 1],
                                       n_hdr[fmbs_pkg::TYPE_OFFSET + 2],
                                       n_hdr[fmbs_pkg::TYPE_OFFSET + 3]});
        in_body  = (r_left != 32'd0);
        hdr_done = !in_body &&
                   (at_long || (at_short && (size8 != fmbs_pkg::SIZE_EXTENDED)));
        use_kind = in_body ? r_kind : new_kind;
        is_final = in_body ? (r_left == 32'd1) : (body_len == 32'd0);
        done_b   = is_final && ((use_kind == fmbs_pkg::KIND_MOOV) ||
                                (use_kind == fmbs_pkg::KIND_MDAT));
        dlv      = done_b && ((use_kind == fmbs_pkg::KIND_MOOV) ? i_init_en
                                                              : (i_frag_en && r_init_done));
        push     = i_acc && (in_body ? (r_kind != fmbs_pkg::KIND_UNKNOWN)
                                     : (hdr_done && !bad_size &&
                                        (new_kind != fmbs_pkg::KIND_UNKNOWN)));
    end

    // Build the command
    always_comb begin
        o_cmd.is_hdr    = !in_body;
        o_cmd.hdr_long  = at_long;
        o_cmd.hdr       = n_hdr;
        o_cmd.body_byte = i_in_byte;
        o_cmd.seg       = (use_kind == fmbs_pkg::KIND_MOOF) ||
                          (use_kind == fmbs_pkg::KIND_MDAT);
        o_cmd.restart   = !in_body && ((use_kind == fmbs_pkg::KIND_FTYP) ||
                                       (use_kind == fmbs_pkg::KIND_MOOF));
        o_cmd.done      = done_b;
        o_cmd.deliver   = dlv;
        o_push          = push;
    end

    // Advance the parse state
    always_comb begin
        n_count     = r_count;
        n_left      = r_left;
        n_kind      = r_kind;
        n_init_done = r_init_done;
        if (i_acc) begin
            if (in_body) begin
                n_left = r_left - 32'd1;
            end else begin
                n_count = cnt_inc;
                if (hdr_done) begin
                    n_count = 5'd0;
                    if (bad_size) begin
                        n_kind = fmbs_pkg::KIND_UNKNOWN;
                    end else begin
                        n_kind = new_kind;
                        n_left = body_len;
                    end
                end
            end
        end
        if (push && done_b && (use_kind == fmbs_pkg::KIND_MOOV) && i_init_en) begin
            n_init_done = 1'b1;
        end
    end

    // Header bytes hold no reset
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 5'd0;
            r_left      <= 32'd0;
            r_kind      <= fmbs_pkg::KIND_UNKNOWN;
            r_init_done <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_left      <= n_left;
            r_kind      <= n_kind;
            r_init_done <= n_init_done;
        end
    end

endmodule
`default_nettype wire

@@ src/fmbs_queue.sv @@
// Short command queue between the front and back ends.
`default_nettype none
module fmbs_queue #(
    parameter int unsigned DEPTH = fmbs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire fmbs_pkg::t_cmd      i_data,
    input  wire logic                i_pop,
    output fmbs_pkg::t_cmd           o_head,
    output fmbs_pkg::t_q_stat        o_stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    fmbs_pkg::t_cmd        r_mem [DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    // Advance pointers with wrap at the last entry, and the fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        n_cnt    = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = CNT_W'(r_cnt + 1'b1);
        end else if (!i_push && i_pop) begin
            n_cnt = CNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));

endmodule
`default_nettype wire

@@ src/fmbs_back.sv @@
// Back end: expands queued commands into output items.
`default_nettype none
module fmbs_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fmbs_pkg::t_cmd      i_head,
    input  wire fmbs_pkg::t_q_stat   i_stat,
    input  wire logic                i_stall,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic [7:0]               o_out_byte,
    output logic                     o_segment_kind,
    output logic                     o_segment_restart,
    output logic                     o_segment_done,
    output logic                     o_deliver,
    output logic                     o_last
);

    logic [3:0]  r_idx, n_idx;
    logic        r_valid, n_valid;
    logic [7:0]  r_byte, n_byte;
    logic        r_seg, n_seg, r_restart, n_restart, r_done, n_done;
    logic        r_dlv, n_dlv, r_last, n_last;
    logic        load, fin;
    logic [3:0]  last_idx;

    // Pick the next item from the queue head
    always_comb begin
        load      = !r_valid || !i_stall;
        last_idx  = i_head.hdr_long ? 4'(fmbs_pkg::HDR_LONG_LEN - 1)
                                    : 4'(fmbs_pkg::HDR_SHORT_LEN - 1);
        fin       = !i_head.is_hdr || (r_idx == last_idx);
        o_pop     = load && !i_stat.empty && fin;
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_byte    = r_byte;
        n_seg     = r_seg;
        n_restart = r_restart;
        n_done    = r_done;
        n_dlv     = r_dlv;
        n_last    = r_last;
        if (load) begin
            n_valid = !i_stat.empty;
            if (!i_stat.empty) begin
                n_byte    = i_head.is_hdr ? i_head.hdr[r_idx] : i_head.body_byte;
                n_seg     = i_head.seg;
                n_restart = i_head.restart && (r_idx == 4'd0);
                n_done    = i_head.done && fin;
                n_dlv     = i_head.deliver && fin;
                n_last    = fin;
                n_idx     = fin ? 4'd0 : r_idx + 4'd1;
            end
        end
    end

    // Output register payload holds no reset
    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_seg     <= n_seg;
        r_restart <= n_restart;
        r_done    <= n_done;
        r_dlv     <= n_dlv;
        r_last    <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign o_valid           = r_valid;
    assign o_out_byte        = r_byte;
    assign o_segment_kind    = r_seg;
    assign o_segment_restart = r_restart;
    assign o_segment_done    = r_done;
    assign o_deliver         = r_dlv;
    assign o_last            = r_last;

endmodule
`default_nettype wire

@@ src/fragmented_mp4_box_splitter_top.sv @@
// Top level of the MP4 box splitter: config registers, front, queue, back.
// A body byte is stored in the command queue, then in the back-end output register.
// A kept box's completed header leaves as 8 or 16 items, one per cycle unless stalled.
// Throughput: 1 input byte per cycle; the queue (QUEUE_DEPTH commands) absorbs bursts,
// and input stalls only while it is full.
// Reset: synchronous, active low; parse state and queue clear, both sink enables set to 1.
`default_nettype none
module fragmented_mp4_box_splitter_top #(
    parameter int unsigned QUEUE_DEPTH = fmbs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fmbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic                          i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [7:0]                    i_in_byte,
    input  wire logic                          i_chunk_end,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [7:0]                         o_out_byte,
    output logic                               o_segment_kind,
    output logic                               o_segment_restart,
    output logic                               o_segment_done,
    output logic                               o_deliver,
    output logic                               o_last
);

    logic              r_init_en, r_frag_en;
    logic              acc, q_push, q_pop;
    fmbs_pkg::t_cmd    q_in, q_head;
    fmbs_pkg::t_q_stat q_stat;

    // Write configuration registers; other indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_en <= 1'b1;
            r_frag_en <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fmbs_pkg::REG_INIT_SINK_EN) begin
                r_init_en <= i_cfg_data;
            end else if (i_cfg_index == fmbs_pkg::REG_FRAG_SINK_EN) begin
                r_frag_en <= i_cfg_data;
            end
        end
    end

    // Chunk end marks carry no parse meaning; accept while the queue has room
    assign o_stall = q_stat.full;
    assign acc     = i_valid && !q_stat.full;

    fmbs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_in_byte (i_in_byte),
        .i_init_en (r_init_en),
        .i_frag_en (r_frag_en),
        .o_cmd     (q_in),
        .o_push    (q_push)
    );

    fmbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    fmbs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (q_head),
        .i_stat            (q_stat),
        .i_stall           (i_stall),
        .o_pop             (q_pop),
        .o_valid           (o_valid),
        .o_out_byte        (o_out_byte),
        .o_segment_kind    (o_segment_kind),
        .o_segment_restart (o_segment_restart),
        .o_segment_done    (o_segment_done),
        .o_deliver         (o_deliver),
        .o_last            (o_last)
    );

    // Never push into a full queue, never pop an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // A done mark closes a box: it is its last item and never also a restart
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_segment_done) |-> (o_last && !o_segment_restart))
        else $error("done mark not on last item of a box");

    // Deliver appears only with a done mark
    a_deliver_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_deliver) |-> o_segment_done)
        else $error("deliver without done mark");

endmodule
`default_nettype wire
